// ===== hdl/sacl_pkg.sv =====
// sacl_pkg: shared types and constants for the set-associative tag store
// no dependencies

package sacl_pkg;

  localparam int unsigned OutSetBits = 2;

  typedef struct packed {
    logic                  hit;
    logic [OutSetBits-1:0] set_index;
    logic                  way_used;
    logic                  filled_empty;
  } result_t;

endpackage

// ===== hdl/set_assoc_cache_lru_tags.sv =====
// set_assoc_cache_lru_tags: tag store with per-set lru replacement by timestamp
// depends on sacl_pkg (result_t)
//
// usage:
//   input channel: in_valid_i / in_ready_o carry one access beat, address_i.
//   output channel: out_valid_o / out_ready_i carry one result beat per access:
//   hit_o, set_index_o, way_used_o, filled_empty_o.
//   an accepted beat sits in the input register while the set is looked up;
//   the ways of the set are compared in parallel and the tag, valid and stamp
//   arrays are updated at the same edge that loads the result register.
//   throughput: one access per cycle while the receiver does not stall,
//   bounded by the single lookup stage.
//   the next access reads the state that the previous one left behind.
//   when the receiver stalls, the result register holds its beat, the input
//   register holds one more access, and in_ready_o drops.
//   reset clears all valid bits, the access clock and both channel valid flags;
//   tags and stamps are only read after a fill has written them.

module set_assoc_cache_lru_tags #(
  parameter int unsigned OFFSET_BITS  = 5,
  parameter int unsigned SET_BITS     = 2,
  parameter int unsigned WAYS         = 2,
  parameter int unsigned ADDRESS_BITS = 32,
  parameter int unsigned STAMP_BITS   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ADDRESS_BITS-1:0]           address_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [sacl_pkg::OutSetBits-1:0]   set_index_o,
  output logic                              way_used_o,
  output logic                              filled_empty_o
);

  localparam int unsigned Sets    = 1 << SET_BITS;
  localparam int unsigned SetW    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned TagRaw  = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
  localparam int unsigned TagW    = (ADDRESS_BITS > OFFSET_BITS + SET_BITS) ? TagRaw : 1;
  localparam int unsigned WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic                    in_valid_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic                    out_valid_q;
  sacl_pkg::result_t       res_q, res_d;

  logic [WAYS-1:0]         valid_q [Sets];
  logic [TagW-1:0]         tag_q   [Sets][WAYS];
  logic [STAMP_BITS-1:0]   stamp_q [Sets][WAYS];
  logic [STAMP_BITS-1:0]   clock_q;

  logic                    advance;
  logic [ADDRESS_BITS-1:0] set_full, tag_full;
  logic [SetW-1:0]         set;
  logic [TagW-1:0]         tag;
  logic                    hit, found_empty;
  logic [WayW-1:0]         way, hit_way, empty_way, lru_way;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign set_full = addr_q >> OFFSET_BITS;
  assign tag_full = addr_q >> (OFFSET_BITS + SET_BITS);
  assign set      = (SET_BITS > 0) ? set_full[SetW-1:0] : '0;
  assign tag      = (ADDRESS_BITS > OFFSET_BITS + SET_BITS) ? tag_full[TagW-1:0] : '0;

  // way selection: lowest matching way, else lowest invalid way, else oldest stamp
  always_comb begin
    hit         = 1'b0;
    hit_way     = '0;
    found_empty = 1'b0;
    empty_way   = '0;
    lru_way     = '0;
    for (int unsigned w = 0; w < WAYS; w++) begin
      if (!hit && valid_q[set][WayW'(w)] && tag_q[set][WayW'(w)] == tag) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
      if (!found_empty && !valid_q[set][WayW'(w)]) begin
        found_empty = 1'b1;
        empty_way   = WayW'(w);
      end
      if (stamp_q[set][WayW'(w)] < stamp_q[set][lru_way]) begin
        lru_way = WayW'(w);
      end
    end
    priority if (hit) begin
      way = hit_way;
    end else if (found_empty) begin
      way = empty_way;
    end else begin
      way = lru_way;
    end
    res_d.hit          = hit;
    res_d.set_index    = sacl_pkg::OutSetBits'(set);
    res_d.way_used     = 1'(way);
    res_d.filled_empty = !hit && found_empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clock_q     <= '0;
      valid_q     <= '{default: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        clock_q     <= clock_q + STAMP_BITS'(1);
        if (!hit) begin
          valid_q[set][way] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      addr_q <= address_i;
    end
    if (advance) begin
      res_q               <= res_d;
      stamp_q[set][way]   <= clock_q;
      if (!hit) begin
        tag_q[set][way] <= tag;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = res_q.hit;
  assign set_index_o    = res_q.set_index;
  assign way_used_o     = res_q.way_used;
  assign filled_empty_o = res_q.filled_empty;

endmodule

// ===== verif/set_assoc_cache_lru_tags_tb.sv =====
// set_assoc_cache_lru_tags_tb: self-checking bench for the 4-set 2-way lru tag store
// depends on sacl_pkg (result_t) and set_assoc_cache_lru_tags; a local lookup model
// predicts every result beat, with random stalls on both channels
`timescale 1ns / 100ps

module set_assoc_cache_lru_tags_tb;

  localparam int unsigned NumSets   = 4;
  localparam int unsigned NumWays   = 2;
  localparam int unsigned NumLines  = NumSets * NumWays;
  localparam int unsigned TagBits   = 25;
  localparam int unsigned PoolDepth = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] address_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic [1:0]  set_index_o;
  logic        way_used_o;
  logic        filled_empty_o;

  // lookup model state
  logic                line_ok    [NumLines];
  logic [TagBits-1:0]  line_tag   [NumLines];
  logic [31:0]         line_time  [NumLines];
  logic [31:0]         access_tick;

  sacl_pkg::result_t pending_results[$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [TagBits-1:0] tag_pool [NumSets][PoolDepth];

  set_assoc_cache_lru_tags u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .set_index_o    (set_index_o),
    .way_used_o     (way_used_o),
    .filled_empty_o (filled_empty_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic sacl_pkg::result_t lookup_line(input logic [31:0] addr);
    logic [1:0]         set_sel;
    logic [TagBits-1:0] tag_val;
    int unsigned        base;
    int unsigned        way;
    logic               found;
    logic               empty;
    sacl_pkg::result_t  res;
    set_sel = addr[6:5];
    tag_val = addr[31:7];
    base    = set_sel * NumWays;
    way     = 0;
    found   = 1'b0;
    empty   = 1'b0;
    for (int unsigned w = 0; w < NumWays; w++) begin
      if (!found && line_ok[base + w] && line_tag[base + w] == tag_val) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (!found) begin
      for (int unsigned w = 0; w < NumWays; w++) begin
        if (!empty && !line_ok[base + w]) begin
          empty = 1'b1;
          way   = w;
        end
      end
      if (!empty) begin
        way = 0;
        for (int unsigned w = 1; w < NumWays; w++) begin
          if (line_time[base + w] < line_time[base + way]) way = w;
        end
      end
      line_ok[base + way]  = 1'b1;
      line_tag[base + way] = tag_val;
    end
    line_time[base + way] = access_tick;
    access_tick           = access_tick + 32'd1;
    res.hit          = found;
    res.set_index    = set_sel;
    res.way_used     = way[0];
    res.filled_empty = empty;
    return res;
  endfunction

  task automatic send_access(input logic [31:0] addr);
    sacl_pkg::result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = lookup_line(addr);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i) begin
    sacl_pkg::result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with none expected, actual hit %0d set %0d way %0d fill %0d",
                 $time, hit_o, set_index_o, way_used_o, filled_empty_o);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("hit", 32'(exp_res.hit), 32'(hit_o));
        check_field("set_index", 32'(exp_res.set_index), 32'(set_index_o));
        check_field("way_used", 32'(exp_res.way_used), 32'(way_used_o));
        check_field("filled_empty", 32'(exp_res.filled_empty), 32'(filled_empty_o));
      end
    end
  end

  // cold misses into empty ways, tag zero against cleared lines, address extremes
  task automatic test_cold_fills();
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0020);
    send_access(32'h0000_0040);
    send_access(32'h8000_0060);
  endtask

  task automatic test_hits();
    send_access(32'h0000_001F);
    send_access(32'hFFFF_FFE0);
    send_access(32'h0000_0025);
    send_access(32'h8000_007F);
  endtask

  task automatic test_lru_eviction();
    send_access(32'h0000_0080);
    send_access(32'h0000_0000);
    send_access(32'h0000_0100);
    send_access(32'h0000_0080);
    send_access(32'h0000_0100);
    send_access(32'h0000_0000);
    send_access(32'h7FFF_FFE0);
    send_access(32'hFFFF_FFE0);
    send_access(32'h5555_5560);
    send_access(32'hAAAA_AAAA);
    send_access(32'h7FFF_FFFF);
  endtask

  task automatic refill_tag_pool();
    for (int s = 0; s < NumSets; s++) begin
      for (int p = 0; p < PoolDepth; p++) tag_pool[s][p] = TagBits'($urandom);
    end
  endtask

  // mostly reuse of a few tags per set so hits and evictions dominate
  task automatic test_random_traffic(input int count);
    logic [31:0] addr;
    logic [1:0]  set_sel;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(49) == 0) begin
        tag_pool[$urandom_range(NumSets - 1)][$urandom_range(PoolDepth - 1)] =
          TagBits'($urandom);
      end
      if ($urandom_range(9) == 0) begin
        addr = $urandom;
      end else begin
        set_sel = 2'($urandom_range(NumSets - 1));
        addr = {tag_pool[set_sel][$urandom_range(PoolDepth - 1)], set_sel,
                5'($urandom)};
      end
      send_access(addr);
      if (i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    address_i      = '0;
    mismatch_count = 0;
    send_idle_pct  = 23;
    recv_idle_pct  = 48;
    access_tick    = '0;
    for (int i = 0; i < NumLines; i++) begin
      line_ok[i]   = 1'b0;
      line_tag[i]  = '0;
      line_time[i] = '0;
    end
    refill_tag_pool();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cold_fills();
    test_hits();
    test_lru_eviction();
    wait_drained();

    test_random_traffic(400);
    send_idle_pct = 48;
    recv_idle_pct = 23;
    refill_tag_pool();
    test_random_traffic(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    refill_tag_pool();
    test_random_traffic(300);

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("set_assoc_cache_lru_tags: match");
    end else begin
      $display("set_assoc_cache_lru_tags: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("set_assoc_cache_lru_tags: mismatch");
    $finish;
  end

endmodule
